// ----- hdl/rc_channel_hbridge_drive_core_defines.svh -----
// Assertion macros shared by the RC channel H-bridge drive RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RC_CHANNEL_HBRIDGE_DRIVE_CORE_DEFINES_SVH
`define RC_CHANNEL_HBRIDGE_DRIVE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RCHB_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc hbridge drive: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RCHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc hbridge drive: next-cycle check failed");

`endif

// ----- hdl/rchb_pkg.sv -----
// Shared constants and types for the RC channel H-bridge drive.
// No dependencies; used by rchb_div and rc_channel_hbridge_drive_core.
package rchb_pkg;

    // configuration register widths
    localparam int CFG_BITS = 12;
    localparam int DB_BITS  = 10;

    // register index codes (byte address / 4)
    localparam logic [1:0] REG_CH_MIN    = 2'd0;
    localparam logic [1:0] REG_CH_MAX    = 2'd1;
    localparam logic [1:0] REG_DEADBAND  = 2'd2;
    localparam logic [1:0] REG_LOSS_LIM  = 2'd3;

    // request kinds
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // bridge direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // filter age counters saturate here
    localparam int         AGE_BITS = 4;
    localparam logic [3:0] AGE_MAX  = 4'd15;

    // map divider: quotient bits resolved one per cycle, saturated result width
    localparam int DIV_STEPS    = 10;
    localparam int DIV_CNT_BITS = 4;
    localparam int DIV_Q_BITS   = 9;

    typedef struct packed {
        logic                  done;
        logic [DIV_Q_BITS-1:0] quot;
    } div_res_t;

endpackage

// ----- hdl/rchb_div.sv -----
// Serial restoring divider for the channel-to-target map, one quotient bit per cycle.
// Quotient saturates to all ones when it would need more than DIV_Q_BITS bits.
// Depends on rchb_pkg and rc_channel_hbridge_drive_core_defines.svh.
`include "rc_channel_hbridge_drive_core_defines.svh"

module rchb_div #(
    parameter int NUM_BITS = 21,
    parameter int DEN_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_BITS-1:0]   num,
    input  logic [DEN_BITS-1:0]   den,
    output rchb_pkg::div_res_t    res
);

    localparam int IW = ((NUM_BITS > DEN_BITS + rchb_pkg::DIV_STEPS - 1) ?
                         NUM_BITS : DEN_BITS + rchb_pkg::DIV_STEPS - 1) + 1;

    logic [IW-1:0]                      rem_reg, rem_next;
    logic [IW-1:0]                      dsh_reg, dsh_next;
    logic [rchb_pkg::DIV_STEPS-1:0]     q_reg, q_next;
    logic [rchb_pkg::DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic                               ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = IW'(num);
            dsh_next  = IW'(den) << (rchb_pkg::DIV_STEPS - 1);
            q_next    = '0;
            cnt_next  = rchb_pkg::DIV_CNT_BITS'(rchb_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_next = rem_reg - dsh_reg;
            q_next   = {q_reg[rchb_pkg::DIV_STEPS-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    // top quotient bit set means the map overflowed; clamp
    assign res.done = done_reg;
    assign res.quot = q_reg[rchb_pkg::DIV_STEPS-1] ? {rchb_pkg::DIV_Q_BITS{1'b1}} :
                      q_reg[rchb_pkg::DIV_Q_BITS-1:0];

    `RCHB_ASSERT_HOLDS(a_div_no_restart, clk, rst_n, start, !busy_reg)
    `RCHB_ASSERT_HOLDS(a_div_cnt_range, clk, rst_n, busy_reg, cnt_reg <= rchb_pkg::DIV_CNT_BITS'(rchb_pkg::DIV_STEPS - 1))

endmodule

// ----- hdl/rc_channel_hbridge_drive_core.sv -----
// RC channel H-bridge drive: one request in, one result out, under a small sequencer.
// Tick without brake: tick check, then output. Sample, at most: prep and classify, the
// serial divider, decide, a slew pass (magnitude, multiply, add, end) through one shared
// multiplier, output. Brake tick that ends the brake runs two slew passes. One request
// at a time; the next is taken once the sequencer is back in idle, as the result lands
// in the output register; a stalled result holds the following one back in output.
// Reset (rst_n, async low) restores default calibration and both filters to 255.0.
// Depends on rchb_pkg, rchb_div and rc_channel_hbridge_drive_core_defines.svh.
`include "rc_channel_hbridge_drive_core_defines.svh"

module rc_channel_hbridge_drive_core #(
    parameter int CHANNEL_BITS = 12,
    parameter int FRAC_BITS    = 16,
    parameter int RAMP_GAP_MS  = 10,
    parameter int BRAKE_MS     = 150
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      op,
    input  logic [CHANNEL_BITS-1:0]   channel,
    // result channel
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [1:0]                bridge_mode,
    output logic [7:0]                duty,
    output logic                      braking,
    output logic                      signal_lost,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int XW  = (CHANNEL_BITS > 13) ? CHANNEL_BITS : 13;
    localparam int SW  = XW + 2;
    localparam int NW  = XW + 8;
    localparam int FW  = 8 + FRAC_BITS;
    localparam longint unsigned GAIN_Q = ((64'd65 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam int GW  = $clog2(GAIN_Q + 1);
    localparam int PW  = FW + GW;
    localparam int BCW = $clog2(BRAKE_MS + 2);
    localparam int CB  = rchb_pkg::CFG_BITS;
    localparam int DB  = rchb_pkg::DB_BITS;

    localparam logic [FW-1:0]  FULL_Q   = {8'hFF, {FRAC_BITS{1'b0}}};
    localparam logic [GW-1:0]  GAIN     = GW'(GAIN_Q);
    localparam logic [PW:0]    HALF_LSB = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [BCW-1:0] BRAKE_LD = BCW'(BRAKE_MS + 1);
    localparam logic [rchb_pkg::AGE_BITS-1:0] GAP = rchb_pkg::AGE_BITS'(RAMP_GAP_MS);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_CLASS  = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_TICK   = 4'd5;
    localparam logic [3:0] S_MAG    = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_ADD    = 4'd8;
    localparam logic [3:0] S_END    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    // configuration
    logic [CB-1:0] ch_min_reg, ch_min_next;
    logic [CB-1:0] ch_max_reg, ch_max_next;
    logic [DB-1:0] db_reg, db_next;
    logic [CB-1:0] loss_lim_reg, loss_lim_next;

    // drive state
    logic [3:0]                    state_reg, state_next;
    logic [1:0]                    dir_stat_reg, dir_stat_next;
    logic [FW-1:0]                 fwd_filt_reg, fwd_filt_next;
    logic [FW-1:0]                 bwd_filt_reg, bwd_filt_next;
    logic [rchb_pkg::AGE_BITS-1:0] fwd_age_reg, fwd_age_next;
    logic [rchb_pkg::AGE_BITS-1:0] bwd_age_reg, bwd_age_next;
    logic [BCW-1:0]                brake_cnt_reg, brake_cnt_next;
    logic [7:0]                    pend_tgt_reg, pend_tgt_next;
    logic                          lost_reg, lost_next;
    logic [1:0]                    held_mode_reg, held_mode_next;
    logic [7:0]                    held_duty_reg, held_duty_next;

    // per-request working registers
    logic [CHANNEL_BITS-1:0]  ch_reg, ch_next;
    logic signed [SW-1:0]     lo_reg, lo_next;
    logic signed [SW-1:0]     hi_reg, hi_next;
    logic [1:0]               samp_dir_reg, samp_dir_next;
    logic [7:0]               tgt_reg, tgt_next;
    // slew job: side (0 forward, 1 backward), target, update held output after
    logic                     sl_side_reg, sl_side_next;
    logic [7:0]               sl_tgt_reg, sl_tgt_next;
    logic                     sl_held_reg, sl_held_next;
    logic                     nx_pend_reg, nx_pend_next;
    logic [FW-1:0]            mag_reg, mag_next;
    logic                     up_reg, up_next;
    logic [PW-1:0]            prod_reg, prod_next;

    // result register
    logic                     res_valid_reg, res_valid_next;
    logic [1:0]               mode_o_reg, mode_o_next;
    logic [7:0]               duty_o_reg, duty_o_next;
    logic                     brk_o_reg, brk_o_next;
    logic                     lost_o_reg, lost_o_next;

    // divider
    logic                     div_start;
    logic [NW-1:0]            div_num;
    logic [CB-1:0]            div_den;
    rchb_pkg::div_res_t       div_res;

    rchb_div #(
        .NUM_BITS (NW),
        .DEN_BITS (CB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    // ---------------- combinational helpers ----------------
    logic                   cfg_wr;
    logic                   req_acc;
    logic [CB:0]            cen_sum;
    logic [CB-1:0]          centre;
    logic signed [SW-1:0]   cen_s, db_s;
    logic signed [SW-1:0]   xs, mns, mxs;
    logic                   fwd_sel, bwd_sel, fwd_zero, bwd_zero;
    logic signed [SW-1:0]   diff, den_s;
    logic [XW-1:0]          v;
    logic [XW-1:0]          ch_x, ll_x;
    logic [FW-1:0]          f_sel, goal;
    logic [rchb_pkg::AGE_BITS-1:0] age_sel;
    logic [PW:0]            rnd;
    logic [FW-1:0]          step;
    logic [FW-1:0]          f_new;
    logic                   rev;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign req_acc = req_valid && !req_stall;

    assign cen_sum = {1'b0, ch_min_reg} + {1'b0, ch_max_reg};
    assign centre  = cen_sum[CB:1];
    assign cen_s   = $signed({{(SW-CB){1'b0}}, centre});
    assign db_s    = $signed({{(SW-DB){1'b0}}, db_reg});

    assign xs  = $signed({{(SW-CHANNEL_BITS){1'b0}}, ch_reg});
    assign mns = $signed({{(SW-CB){1'b0}}, ch_min_reg});
    assign mxs = $signed({{(SW-CB){1'b0}}, ch_max_reg});

    assign fwd_sel  = (xs > lo_reg);
    assign bwd_sel  = (xs < hi_reg);
    assign fwd_zero = (mxs <= lo_reg);
    assign bwd_zero = (hi_reg <= mns) || (xs <= mns);

    assign diff    = fwd_sel ? (xs - lo_reg) : (xs - mns);
    assign den_s   = fwd_sel ? (mxs - lo_reg) : (hi_reg - mns);
    assign v       = diff[XW-1:0];
    // times 255 as a shift and subtract
    assign div_num = {v, 8'h00} - NW'(v);
    assign div_den = den_s[CB-1:0];

    assign ch_x = XW'(ch_reg);
    assign ll_x = XW'(loss_lim_reg);

    assign f_sel   = sl_side_reg ? bwd_filt_reg : fwd_filt_reg;
    assign age_sel = sl_side_reg ? bwd_age_reg : fwd_age_reg;
    assign goal    = {sl_tgt_reg, {FRAC_BITS{1'b0}}};
    assign rnd     = {1'b0, prod_reg} + HALF_LSB;
    assign step    = FW'(rnd >> FRAC_BITS);
    assign f_new   = up_reg ? (f_sel + step) : (f_sel - step);

    assign rev = ((samp_dir_reg == rchb_pkg::DIR_FWD) && (dir_stat_reg == rchb_pkg::DIR_BWD)) ||
                 ((samp_dir_reg == rchb_pkg::DIR_BWD) && (dir_stat_reg == rchb_pkg::DIR_FWD));

    // ---------------- configuration port ----------------
    always_comb
    begin
        ch_min_next   = ch_min_reg;
        ch_max_next   = ch_max_reg;
        db_next       = db_reg;
        loss_lim_next = loss_lim_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                rchb_pkg::REG_CH_MIN:   ch_min_next   = pwdata[CB-1:0];
                rchb_pkg::REG_CH_MAX:   ch_max_next   = pwdata[CB-1:0];
                rchb_pkg::REG_DEADBAND: db_next       = pwdata[DB-1:0];
                rchb_pkg::REG_LOSS_LIM: loss_lim_next = pwdata[CB-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rchb_pkg::REG_CH_MIN:   prdata = {{(32-CB){1'b0}}, ch_min_reg};
            rchb_pkg::REG_CH_MAX:   prdata = {{(32-CB){1'b0}}, ch_max_reg};
            rchb_pkg::REG_DEADBAND: prdata = {{(32-DB){1'b0}}, db_reg};
            rchb_pkg::REG_LOSS_LIM: prdata = {{(32-CB){1'b0}}, loss_lim_reg};
        endcase
    end

    assign pready = 1'b1;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        dir_stat_next  = dir_stat_reg;
        fwd_filt_next  = fwd_filt_reg;
        bwd_filt_next  = bwd_filt_reg;
        fwd_age_next   = fwd_age_reg;
        bwd_age_next   = bwd_age_reg;
        brake_cnt_next = brake_cnt_reg;
        pend_tgt_next  = pend_tgt_reg;
        lost_next      = lost_reg;
        held_mode_next = held_mode_reg;
        held_duty_next = held_duty_reg;
        ch_next        = ch_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        samp_dir_next  = samp_dir_reg;
        tgt_next       = tgt_reg;
        sl_side_next   = sl_side_reg;
        sl_tgt_next    = sl_tgt_reg;
        sl_held_next   = sl_held_reg;
        nx_pend_next   = nx_pend_reg;
        mag_next       = mag_reg;
        up_next        = up_reg;
        prod_next      = prod_reg;
        mode_o_next    = mode_o_reg;
        duty_o_next    = duty_o_reg;
        brk_o_next     = brk_o_reg;
        lost_o_next    = lost_o_reg;
        res_valid_next = res_valid_reg && res_stall;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    ch_next = channel;
                    if (op == rchb_pkg::OP_SAMPLE)
                        // a sample during brake is dropped entirely, but still answered with a result
                        state_next = (brake_cnt_reg != '0) ? S_OUT : S_PREP;
                    else
                    begin
                        if (fwd_age_reg != rchb_pkg::AGE_MAX)
                            fwd_age_next = fwd_age_reg + 1'b1;
                        if (bwd_age_reg != rchb_pkg::AGE_MAX)
                            bwd_age_next = bwd_age_reg + 1'b1;
                        state_next = S_TICK;
                    end
                end
            end

            S_PREP:
            begin
                lo_next    = cen_s + db_s;
                hi_next    = cen_s - db_s;
                state_next = S_CLASS;
            end

            S_CLASS:
            begin
                priority if (lost_reg && !(ch_x > ll_x))
                    state_next = S_OUT;
                else if (!lost_reg && (ch_x < ll_x))
                begin
                    lost_next      = 1'b1;
                    held_mode_next = rchb_pkg::DIR_STOP;
                    held_duty_next = 8'd0;
                    state_next     = S_OUT;
                end
                else
                begin
                    lost_next = 1'b0;
                    priority if (fwd_sel)
                    begin
                        samp_dir_next = rchb_pkg::DIR_FWD;
                        tgt_next      = 8'd0;
                        if (fwd_zero)
                            state_next = S_DECIDE;
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    else if (bwd_sel)
                    begin
                        samp_dir_next = rchb_pkg::DIR_BWD;
                        tgt_next      = 8'd0;
                        if (bwd_zero)
                            state_next = S_DECIDE;
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        dir_stat_next  = rchb_pkg::DIR_STOP;
                        held_mode_next = rchb_pkg::DIR_STOP;
                        held_duty_next = 8'd0;
                        state_next     = S_OUT;
                    end
                end
            end

            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (samp_dir_reg == rchb_pkg::DIR_FWD)
                        tgt_next = (div_res.quot >= rchb_pkg::DIV_Q_BITS'(255)) ? 8'd0 :
                                   8'(rchb_pkg::DIV_Q_BITS'(255) - div_res.quot);
                    else
                        tgt_next = (div_res.quot > rchb_pkg::DIV_Q_BITS'(255)) ? 8'd255 :
                                   div_res.quot[7:0];
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                dir_stat_next = samp_dir_reg;
                nx_pend_next  = 1'b0;
                if (rev)
                begin
                    // brake the old side first, new side waits in pend_tgt
                    pend_tgt_next  = tgt_reg;
                    brake_cnt_next = BRAKE_LD;
                    sl_side_next   = (samp_dir_reg == rchb_pkg::DIR_FWD);
                    sl_tgt_next    = 8'd255;
                    sl_held_next   = 1'b0;
                end
                else
                begin
                    sl_side_next = (samp_dir_reg == rchb_pkg::DIR_BWD);
                    sl_tgt_next  = tgt_reg;
                    sl_held_next = 1'b1;
                end
                state_next = S_MAG;
            end

            S_TICK:
            begin
                if (brake_cnt_reg != '0)
                begin
                    brake_cnt_next = brake_cnt_reg - 1'b1;
                    sl_side_next   = (dir_stat_reg == rchb_pkg::DIR_FWD);
                    sl_tgt_next    = 8'd255;
                    sl_held_next   = 1'b0;
                    nx_pend_next   = (brake_cnt_reg == BCW'(1));
                    state_next     = S_MAG;
                end
                else
                    state_next = S_OUT;
            end

            S_MAG:
            begin
                if (age_sel > GAP)
                begin
                    up_next    = (goal >= f_sel);
                    mag_next   = (goal >= f_sel) ? (goal - f_sel) : (f_sel - goal);
                    state_next = S_MUL;
                end
                else
                    state_next = S_END;
            end

            S_MUL:
            begin
                prod_next  = PW'(mag_reg) * PW'(GAIN);
                state_next = S_ADD;
            end

            S_ADD:
            begin
                if (sl_side_reg)
                begin
                    bwd_filt_next = f_new;
                    bwd_age_next  = '0;
                end
                else
                begin
                    fwd_filt_next = f_new;
                    fwd_age_next  = '0;
                end
                state_next = S_END;
            end

            S_END:
            begin
                if (sl_held_reg)
                begin
                    held_duty_next = f_sel[FW-1:FRAC_BITS];
                    held_mode_next = sl_side_reg ? rchb_pkg::DIR_BWD : rchb_pkg::DIR_FWD;
                end
                if (nx_pend_reg)
                begin
                    // brake ran out: drive the pending side
                    sl_side_next = (dir_stat_reg == rchb_pkg::DIR_BWD);
                    sl_tgt_next  = pend_tgt_reg;
                    sl_held_next = 1'b1;
                    nx_pend_next = 1'b0;
                    state_next   = S_MAG;
                end
                else
                    state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    priority if (lost_reg)
                    begin
                        mode_o_next = rchb_pkg::DIR_STOP;
                        duty_o_next = 8'd0;
                        brk_o_next  = 1'b0;
                    end
                    else if (brake_cnt_reg != '0)
                    begin
                        brk_o_next = 1'b1;
                        if (dir_stat_reg == rchb_pkg::DIR_FWD)
                        begin
                            mode_o_next = rchb_pkg::DIR_BWD;
                            duty_o_next = bwd_filt_reg[FW-1:FRAC_BITS];
                        end
                        else
                        begin
                            mode_o_next = rchb_pkg::DIR_FWD;
                            duty_o_next = fwd_filt_reg[FW-1:FRAC_BITS];
                        end
                    end
                    else
                    begin
                        brk_o_next  = 1'b0;
                        mode_o_next = held_mode_reg;
                        duty_o_next = (held_mode_reg == rchb_pkg::DIR_STOP) ? 8'd0 :
                                      held_duty_reg;
                    end
                    lost_o_next = lost_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_min_reg    <= CB'(1000);
            ch_max_reg    <= CB'(2000);
            db_reg        <= DB'(40);
            loss_lim_reg  <= CB'(800);
            state_reg     <= S_IDLE;
            dir_stat_reg  <= rchb_pkg::DIR_STOP;
            fwd_filt_reg  <= FULL_Q;
            bwd_filt_reg  <= FULL_Q;
            fwd_age_reg   <= '0;
            bwd_age_reg   <= '0;
            brake_cnt_reg <= '0;
            pend_tgt_reg  <= 8'd0;
            lost_reg      <= 1'b0;
            held_mode_reg <= rchb_pkg::DIR_STOP;
            held_duty_reg <= 8'd0;
            nx_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ch_min_reg    <= ch_min_next;
            ch_max_reg    <= ch_max_next;
            db_reg        <= db_next;
            loss_lim_reg  <= loss_lim_next;
            state_reg     <= state_next;
            dir_stat_reg  <= dir_stat_next;
            fwd_filt_reg  <= fwd_filt_next;
            bwd_filt_reg  <= bwd_filt_next;
            fwd_age_reg   <= fwd_age_next;
            bwd_age_reg   <= bwd_age_next;
            brake_cnt_reg <= brake_cnt_next;
            pend_tgt_reg  <= pend_tgt_next;
            lost_reg      <= lost_next;
            held_mode_reg <= held_mode_next;
            held_duty_reg <= held_duty_next;
            nx_pend_reg   <= nx_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        samp_dir_reg <= samp_dir_next;
        tgt_reg      <= tgt_next;
        sl_side_reg  <= sl_side_next;
        sl_tgt_reg   <= sl_tgt_next;
        sl_held_reg  <= sl_held_next;
        mag_reg      <= mag_next;
        up_reg       <= up_next;
        prod_reg     <= prod_next;
        mode_o_reg   <= mode_o_next;
        duty_o_reg   <= duty_o_next;
        brk_o_reg    <= brk_o_next;
        lost_o_reg   <= lost_o_next;
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign res_valid   = res_valid_reg;
    assign bridge_mode = mode_o_reg;
    assign duty        = duty_o_reg;
    assign braking     = brk_o_reg;
    assign signal_lost = lost_o_reg;

    `RCHB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_acc, state_reg != S_IDLE)
    `RCHB_ASSERT_HOLDS(a_brake_has_dir, clk, rst_n, brake_cnt_reg != '0, (dir_stat_reg == rchb_pkg::DIR_FWD) || (dir_stat_reg == rchb_pkg::DIR_BWD))
    `RCHB_ASSERT_HOLDS(a_lost_holds_stop, clk, rst_n, lost_reg, (held_mode_reg == rchb_pkg::DIR_STOP) && (brake_cnt_reg == '0))
    `RCHB_ASSERT_HOLDS(a_res_brake_not_lost, clk, rst_n, res_valid && braking, !signal_lost && (bridge_mode != rchb_pkg::DIR_STOP))

endmodule
